@@ src/amdfs_pkg.sv @@
// Shared types, sizes and helper functions for the adjacency-matrix search core.
// Used by every module of the block; depends on nothing.
`default_nettype none

package amdfs_pkg;

    localparam int NUM_VERTICES = 32;
    localparam int MAX_VISITS   = 32;
    localparam int VERT_W       = $clog2(NUM_VERTICES);
    localparam int EXT_W        = VERT_W + 1;
    localparam int ID_W         = 8;
    localparam int CMD_W        = 2;
    localparam int VIS_W        = 5;
    localparam int CNT_W        = $clog2(MAX_VISITS + 1);

    typedef logic [VERT_W-1:0]       vert_t;
    typedef logic [NUM_VERTICES-1:0] row_t;
    typedef logic [EXT_W-1:0]        ext_t;
    typedef logic [ID_W-1:0]         id_t;
    typedef logic [VIS_W-1:0]        vis_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef struct packed {
        logic  en;
        vert_t addr;
    } adj_rd_t;

    typedef struct packed {
        logic  en;
        vert_t addr;
        row_t  data;
    } adj_wr_t;

    typedef struct packed {
        logic  en;
        vert_t addr;
    } stk_rd_t;

    typedef struct packed {
        logic  en;
        vert_t addr;
        vert_t data;
    } stk_wr_t;

    // One-hot row with only the bit of vertex v set.
    function automatic row_t vert_bit(input vert_t v);
        return row_t'(1) << v;
    endfunction

    // Index of the lowest set bit; zero when no bit is set.
    function automatic vert_t lowest_set(input row_t x);
        vert_t r;
        r = '0;
        for (int i = NUM_VERTICES - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                r = vert_t'(i);
            end
        end
        return r;
    endfunction

    // Mask of all vertices below the extent.
    function automatic row_t extent_mask(input ext_t e);
        row_t m;
        for (int i = 0; i < NUM_VERTICES; i++)
        begin
            m[i] = (ext_t'(i) < e);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ src/amdfs_adj_mem.sv @@
// Adjacency row memory: one write and one registered read per cycle.
// Depends on amdfs_pkg; rows never written read as zero through per-row valid bits.
`default_nettype none

module amdfs_adj_mem
    import amdfs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire adj_rd_t rd_req,
    input  wire adj_wr_t wr_req,
    output row_t         rd_data
);

    row_t                    mem [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] row_vld_reg;
    row_t                    rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.addr] <= wr_req.data;
        end
    end

    // A row reads as zero until it has been written once since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_data_reg <= '0;
        end
        else
        begin
            if (wr_req.en)
            begin
                row_vld_reg[wr_req.addr] <= 1'b1;
            end
            if (rd_req.en)
            begin
                rd_data_reg <= row_vld_reg[rd_req.addr] ? mem[rd_req.addr] : '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/amdfs_stack_mem.sv @@
// Search stack memory of vertex ids: one write and one registered read per cycle.
// Depends on amdfs_pkg; contents are undefined until pushed.
`default_nettype none

module amdfs_stack_mem
    import amdfs_pkg::*;
(
    input  wire logic    clk,
    input  wire stk_rd_t rd_req,
    input  wire stk_wr_t wr_req,
    output vert_t        rd_data
);

    vert_t mem [NUM_VERTICES];
    vert_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en)
        begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/adjacency_matrix_dfs_core.sv @@
// Top level of the adjacency-matrix graph store with depth-first search.
// Depends on amdfs_pkg, amdfs_adj_mem and amdfs_stack_mem.
//
// Usage: one command item enters on the input channel (cmd, vertex_a, vertex_b)
// when in_valid is high and in_stall is low. Add, remove and query each give one
// result item; a search gives one result item per vertex visited, in preorder,
// with last set on the final one. A start outside the graph gives a single item
// with search_empty set, and ids at or beyond the vertex count are flagged with
// out_of_range and the command is ignored.
// Flow: the block works on one command at a time and raises in_stall until its
// last result has been loaded into the output register. A query reads row a;
// an add or remove does one read-modify-write of the adjacency memory per
// endpoint (only one when both endpoints are the same vertex). A search reads
// one adjacency row each step, and a pop reads the stack before that row; the
// walk is cut off at 32 visits.
// Results wait in an output register; while out_stall is high that register
// holds its item and the sequencer pauses at its next result, but a new command
// is taken as soon as the last result of the previous one sits in the register.
// Reset clears the matrix (through per-row valid bits, so no clearing pass), the
// extent and the stack depth, and leaves the output channel empty.
`default_nettype none

module adjacency_matrix_dfs_core
    import amdfs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [CMD_W-1:0] cmd,
    input  wire logic [ID_W-1:0]  vertex_a,
    input  wire logic [ID_W-1:0]  vertex_b,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [VIS_W-1:0]      visit_vertex,
    output logic                  edge_present,
    output logic                  search_empty,
    output logic                  out_of_range,
    output logic                  last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RMW_A,
        S_RMW_B,
        S_EVAL,
        S_POP,
        S_FLUSH
    } state_t;

    localparam id_t NUM_V_ID = id_t'(NUM_VERTICES);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    id_t    a_reg, a_next;
    id_t    b_reg, b_next;
    ext_t   extent_reg, extent_next;
    row_t   visited_reg, visited_next;
    ext_t   depth_reg, depth_next;
    cnt_t   count_reg, count_next;
    vert_t  top_reg, top_next;

    // The pending result: held back until it is known whether it is the last.
    vis_t   pend_vertex_reg, pend_vertex_next;
    logic   pend_edge_reg, pend_edge_next;
    logic   pend_empty_reg, pend_empty_next;
    logic   pend_oor_reg, pend_oor_next;

    logic   out_valid_reg, out_valid_next;
    vis_t   out_vertex_reg, out_vertex_next;
    logic   out_edge_reg, out_edge_next;
    logic   out_empty_reg, out_empty_next;
    logic   out_oor_reg, out_oor_next;
    logic   out_last_reg, out_last_next;

    adj_rd_t adj_rd;
    adj_wr_t adj_wr;
    row_t    adj_rdata;
    stk_rd_t stk_rd;
    stk_wr_t stk_wr;
    vert_t   stk_rdata;

    vert_t a_v;
    vert_t b_v;
    logic  a_oor;
    logic  b_oor;
    row_t  cand;
    vert_t pick;
    ext_t  hi;
    ext_t  depth_m2;
    logic  out_free;
    logic  out_load;
    logic  load_last;

    amdfs_adj_mem u_adj_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_req  (adj_rd),
        .wr_req  (adj_wr),
        .rd_data (adj_rdata)
    );

    amdfs_stack_mem u_stack_mem (
        .clk     (clk),
        .rd_req  (stk_rd),
        .wr_req  (stk_wr),
        .rd_data (stk_rdata)
    );

    assign a_v      = a_reg[VERT_W-1:0];
    assign b_v      = b_reg[VERT_W-1:0];
    assign a_oor    = (a_reg >= NUM_V_ID);
    assign b_oor    = (b_reg >= NUM_V_ID);
    assign cand     = adj_rdata & ~visited_reg & extent_mask(extent_reg);
    assign pick     = lowest_set(cand);
    assign hi       = ((a_v > b_v) ? ext_t'(a_v) : ext_t'(b_v)) + ext_t'(1);
    assign depth_m2 = depth_reg - ext_t'(2);
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign visit_vertex = out_vertex_reg;
    assign edge_present = out_edge_reg;
    assign search_empty = out_empty_reg;
    assign out_of_range = out_oor_reg;
    assign last         = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        extent_next      = extent_reg;
        visited_next     = visited_reg;
        depth_next       = depth_reg;
        count_next       = count_reg;
        top_next         = top_reg;
        pend_vertex_next = pend_vertex_reg;
        pend_edge_next   = pend_edge_reg;
        pend_empty_next  = pend_empty_reg;
        pend_oor_next    = pend_oor_reg;
        adj_rd           = '0;
        adj_wr           = '0;
        stk_rd           = '0;
        stk_wr           = '0;
        out_load         = 1'b0;
        load_last        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(cmd);
                    a_next     = vertex_a;
                    b_next     = vertex_b;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                pend_vertex_next = '0;
                pend_edge_next   = 1'b0;
                pend_empty_next  = 1'b0;
                pend_oor_next    = 1'b0;
                if (cmd_reg == CMD_SEARCH)
                begin
                    if (a_oor)
                    begin
                        pend_empty_next = 1'b1;
                        pend_oor_next   = 1'b1;
                        state_next      = S_FLUSH;
                    end
                    else if (a_reg >= id_t'(extent_reg))
                    begin
                        pend_empty_next = 1'b1;
                        state_next      = S_FLUSH;
                    end
                    else
                    begin
                        // The start vertex becomes the first pending visit.
                        visited_next     = vert_bit(a_v);
                        stk_wr           = '{en: 1'b1, addr: '0, data: a_v};
                        depth_next       = ext_t'(1);
                        count_next       = cnt_t'(1);
                        top_next         = a_v;
                        pend_vertex_next = vis_t'(a_v);
                        adj_rd           = '{en: 1'b1, addr: a_v};
                        state_next       = S_EVAL;
                    end
                end
                else if (a_oor || b_oor)
                begin
                    pend_oor_next = 1'b1;
                    state_next    = S_FLUSH;
                end
                else
                begin
                    adj_rd     = '{en: 1'b1, addr: a_v};
                    state_next = S_RMW_A;
                end
            end
            S_RMW_A:
            begin
                unique case (cmd_reg)
                    CMD_QUERY:
                    begin
                        pend_edge_next = adj_rdata[b_v];
                        state_next     = S_FLUSH;
                    end
                    CMD_ADD:
                    begin
                        adj_wr = '{en: 1'b1, addr: a_v, data: adj_rdata | vert_bit(b_v)};
                        if (hi > extent_reg)
                        begin
                            extent_next = hi;
                        end
                        if (a_v != b_v)
                        begin
                            adj_rd     = '{en: 1'b1, addr: b_v};
                            state_next = S_RMW_B;
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        adj_wr = '{en: 1'b1, addr: a_v, data: adj_rdata & ~vert_bit(b_v)};
                        if (a_v != b_v)
                        begin
                            adj_rd     = '{en: 1'b1, addr: b_v};
                            state_next = S_RMW_B;
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        state_next = S_FLUSH;
                    end
                    default:
                    begin
                        state_next = S_FLUSH;
                    end
                endcase
            end
            S_RMW_B:
            begin
                // The read of row b never overlaps the write of row a, as a != b here.
                adj_wr.en   = 1'b1;
                adj_wr.addr = b_v;
                adj_wr.data = (cmd_reg == CMD_ADD) ? (adj_rdata | vert_bit(a_v))
                                                   : (adj_rdata & ~vert_bit(a_v));
                state_next  = S_FLUSH;
            end
            S_EVAL:
            begin
                if (cand != '0)
                begin
                    if (out_free)
                    begin
                        // Release the previous visit and hold the new one back.
                        out_load         = 1'b1;
                        pend_vertex_next = vis_t'(pick);
                        visited_next     = visited_reg | vert_bit(pick);
                        stk_wr           = '{en: 1'b1, addr: depth_reg[VERT_W-1:0], data: pick};
                        depth_next       = depth_reg + ext_t'(1);
                        top_next         = pick;
                        count_next       = count_reg + cnt_t'(1);
                        if (count_reg == cnt_t'(MAX_VISITS - 1))
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            adj_rd = '{en: 1'b1, addr: pick};
                        end
                    end
                end
                else
                begin
                    depth_next = depth_reg - ext_t'(1);
                    if (depth_reg == ext_t'(1))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        stk_rd     = '{en: 1'b1, addr: depth_m2[VERT_W-1:0]};
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                top_next   = stk_rdata;
                adj_rd     = '{en: 1'b1, addr: stk_rdata};
                state_next = S_EVAL;
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_last  = 1'b1;
                    depth_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next  = out_valid_reg;
        out_vertex_next = out_vertex_reg;
        out_edge_next   = out_edge_reg;
        out_empty_next  = out_empty_reg;
        out_oor_next    = out_oor_reg;
        out_last_next   = out_last_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_vertex_next = pend_vertex_reg;
            out_edge_next   = pend_edge_reg;
            out_empty_next  = pend_empty_reg;
            out_oor_next    = pend_oor_reg;
            out_last_next   = load_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= CMD_ADD;
            a_reg           <= '0;
            b_reg           <= '0;
            extent_reg      <= '0;
            visited_reg     <= '0;
            depth_reg       <= '0;
            count_reg       <= '0;
            top_reg         <= '0;
            pend_vertex_reg <= '0;
            pend_edge_reg   <= 1'b0;
            pend_empty_reg  <= 1'b0;
            pend_oor_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_vertex_reg  <= '0;
            out_edge_reg    <= 1'b0;
            out_empty_reg   <= 1'b0;
            out_oor_reg     <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            a_reg           <= a_next;
            b_reg           <= b_next;
            extent_reg      <= extent_next;
            visited_reg     <= visited_next;
            depth_reg       <= depth_next;
            count_reg       <= count_next;
            top_reg         <= top_next;
            pend_vertex_reg <= pend_vertex_next;
            pend_edge_reg   <= pend_edge_next;
            pend_empty_reg  <= pend_empty_next;
            pend_oor_reg    <= pend_oor_next;
            out_valid_reg   <= out_valid_next;
            out_vertex_reg  <= out_vertex_next;
            out_edge_reg    <= out_edge_next;
            out_empty_reg   <= out_empty_next;
            out_oor_reg     <= out_oor_next;
            out_last_reg    <= out_last_next;
        end
    end

    // The stack never holds more entries than there are vertices.
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= ext_t'(NUM_VERTICES))
        else $error("stack depth beyond vertex count");

    // A search never counts more visits than the result limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MAX_VISITS))
        else $error("visit count beyond limit");

    // The vertex whose row is being examined has always been visited.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> visited_reg[top_reg])
        else $error("stack top not marked visited");

    // While walking, the stack is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL || state_reg == S_POP) |-> (depth_reg != '0))
        else $error("walk with empty stack");

    // An accepted command always starts the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CHECK))
        else $error("accepted command not decoded");

endmodule

`default_nettype wire
